// File: design/ffcg_pkg.sv
`default_nettype none
package ffcg_pkg;

  localparam int unsigned MAX_WIDTH = 65536;

  localparam int IDX_BITS   = 16;
  localparam int W_BITS     = 17;
  localparam int Q_BITS     = 15;
  localparam int CUT_BITS   = 17;
  localparam int ORD_BITS   = 10;
  localparam int VAL_BITS   = 24;
  localparam int CQ_BITS    = 32;
  localparam int MANT_BITS  = 31;
  localparam int FRAC_BITS  = 16;
  localparam int DEN_BITS   = 64;
  localparam int DIV1_STEPS = 32;
  localparam int LOG_STEPS  = 16;
  localparam int EXP_STEPS  = 16;
  localparam int DIV2_STEPS = 24;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 17;

  localparam logic [W_BITS-1:0] W_LIMIT = W_BITS'(MAX_WIDTH & ~32'd3);

  localparam logic [CFG_IDX_BITS-1:0] CFG_FILTER_TYPE  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LINE_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CUTOFF_FRAC  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ORDER_SCALED = 2'd3;

  localparam logic FILTER_RAMP = 1'b0;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // k-th successive square root of two, Q1.30
  function automatic logic [MANT_BITS-1:0] exp2_root(input int k);
    logic [63:0] r;
    r = isqrt64(64'd2 << 60);
    for (int j = 1; j < k; j++) begin
      r = isqrt64(r << 30);
    end
    return r[MANT_BITS-1:0];
  endfunction

  localparam logic [MANT_BITS-1:0] EXP_ROOT [1:EXP_STEPS] = '{
    exp2_root(1),  exp2_root(2),  exp2_root(3),  exp2_root(4),
    exp2_root(5),  exp2_root(6),  exp2_root(7),  exp2_root(8),
    exp2_root(9),  exp2_root(10), exp2_root(11), exp2_root(12),
    exp2_root(13), exp2_root(14), exp2_root(15), exp2_root(16)
  };

  function automatic logic [4:0] msb_index(input logic [CQ_BITS-1:0] v);
    logic [4:0] m;
    m = '0;
    for (int i = 0; i < CQ_BITS; i++) begin
      if (v[i]) m = 5'(i);
    end
    return m;
  endfunction

  // mantissa in Q1.30 with the top set bit at bit 30
  function automatic logic [MANT_BITS-1:0] normalize(input logic [CQ_BITS-1:0] v,
                                                     input logic [4:0] m);
    logic [62:0] t;
    t = {31'b0, v} << (6'd62 - {1'b0, m});
    return t[62:32];
  endfunction

endpackage
`default_nettype wire

// File: design/frequency_filter_coefficient_gen_unit.sv
// Ramp / Butterworth frequency filter coefficient generator. Each item carries a
// position in a line of interleaved complex values and returns one Q0.24
// coefficient. The block takes one item every cycle unless the output stalls.
// It is built from the pipelined divider for q/W (32 stages), the log2 squaring
// chain (16 stages), the exp2 product chain (16 stages) and the final divider
// (24 stages). A stall on the output holds the whole pipeline. Configuration
// registers may only be written while no item is in flight.
`default_nettype none
module frequency_filter_coefficient_gen_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [ffcg_pkg::IDX_BITS-1:0]      in_coefficient_index,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [ffcg_pkg::VAL_BITS-1:0]           out_coefficient_value,
  input  wire logic                               cfg_write_en,
  input  wire logic [ffcg_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [ffcg_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import ffcg_pkg::*;

  logic                  filter_type_r;
  logic [W_BITS-1:0]     line_width_r;
  logic [CUT_BITS-1:0]   cutoff_r;
  logic [ORD_BITS-1:0]   order_r;

  logic en;

  // line setup
  logic [W_BITS-1:0]     w_lim;
  logic [Q_BITS-1:0]     w4;
  logic [IDX_BITS-1:0]   half;
  logic [Q_BITS-1:0]     p;
  logic [Q_BITS-1:0]     q;
  logic                  idx_ok;

  // divider for q * 2^34 / W
  logic                  d1_v_r   [0:DIV1_STEPS];
  logic                  d1_z_r   [0:DIV1_STEPS];
  logic [W_BITS-1:0]     d1_rem_r [0:DIV1_STEPS];
  logic [CQ_BITS-1:0]    d1_quo_r [0:DIV1_STEPS];
  logic                  d1_v_nxt   [0:DIV1_STEPS];
  logic                  d1_z_nxt   [0:DIV1_STEPS];
  logic [W_BITS-1:0]     d1_rem_nxt [0:DIV1_STEPS];
  logic [CQ_BITS-1:0]    d1_quo_nxt [0:DIV1_STEPS];

  // log2 squaring chain, lane a for c, lane b for the cutoff
  logic                  lg_v_r  [0:LOG_STEPS];
  logic                  lg_z_r  [0:LOG_STEPS];
  logic [CQ_BITS-1:0]    lg_cq_r [0:LOG_STEPS];
  logic [4:0]            lg_ma_r [0:LOG_STEPS];
  logic [4:0]            lg_mb_r [0:LOG_STEPS];
  logic [MANT_BITS-1:0]  lg_xa_r [0:LOG_STEPS];
  logic [MANT_BITS-1:0]  lg_xb_r [0:LOG_STEPS];
  logic [FRAC_BITS-1:0]  lg_fa_r [0:LOG_STEPS];
  logic [FRAC_BITS-1:0]  lg_fb_r [0:LOG_STEPS];
  logic                  lg_v_nxt  [0:LOG_STEPS];
  logic                  lg_z_nxt  [0:LOG_STEPS];
  logic [CQ_BITS-1:0]    lg_cq_nxt [0:LOG_STEPS];
  logic [4:0]            lg_ma_nxt [0:LOG_STEPS];
  logic [4:0]            lg_mb_nxt [0:LOG_STEPS];
  logic [MANT_BITS-1:0]  lg_xa_nxt [0:LOG_STEPS];
  logic [MANT_BITS-1:0]  lg_xb_nxt [0:LOG_STEPS];
  logic [FRAC_BITS-1:0]  lg_fa_nxt [0:LOG_STEPS];
  logic [FRAC_BITS-1:0]  lg_fb_nxt [0:LOG_STEPS];

  logic                  la_v_r, la_v_nxt, la_z_r, la_z_nxt;
  logic [CQ_BITS-1:0]    la_cq_r, la_cq_nxt;
  logic signed [23:0]    la_lx_r, la_lx_nxt;

  logic                  lb_v_r, lb_v_nxt, lb_z_r, lb_z_nxt;
  logic [CQ_BITS-1:0]    lb_cq_r, lb_cq_nxt;
  logic signed [31:0]    lb_y_r, lb_y_nxt;
  logic signed [34:0]    lb_prod;

  // exp2 of the fraction
  logic                  ex_v_r   [0:EXP_STEPS];
  logic                  ex_z_r   [0:EXP_STEPS];
  logic [CQ_BITS-1:0]    ex_cq_r  [0:EXP_STEPS];
  logic signed [15:0]    ex_yi_r  [0:EXP_STEPS];
  logic [FRAC_BITS-1:0]  ex_yf_r  [0:EXP_STEPS];
  logic [MANT_BITS-1:0]  ex_acc_r [0:EXP_STEPS];
  logic                  ex_v_nxt   [0:EXP_STEPS];
  logic                  ex_z_nxt   [0:EXP_STEPS];
  logic [CQ_BITS-1:0]    ex_cq_nxt  [0:EXP_STEPS];
  logic signed [15:0]    ex_yi_nxt  [0:EXP_STEPS];
  logic [FRAC_BITS-1:0]  ex_yf_nxt  [0:EXP_STEPS];
  logic [MANT_BITS-1:0]  ex_acc_nxt [0:EXP_STEPS];

  logic                  dn_v_r, dn_v_nxt, dn_z_r, dn_z_nxt, dn_big_r, dn_big_nxt;
  logic [CQ_BITS-1:0]    dn_cq_r, dn_cq_nxt;
  logic [DEN_BITS-1:0]   dn_den_r, dn_den_nxt;

  // divider for c * 2^22 / den
  logic                  dv_v_r   [0:DIV2_STEPS];
  logic                  dv_z_r   [0:DIV2_STEPS];
  logic                  dv_big_r [0:DIV2_STEPS];
  logic [CQ_BITS-1:0]    dv_cq_r  [0:DIV2_STEPS];
  logic [DEN_BITS-1:0]   dv_den_r [0:DIV2_STEPS];
  logic [DEN_BITS-1:0]   dv_rem_r [0:DIV2_STEPS];
  logic [VAL_BITS-1:0]   dv_quo_r [0:DIV2_STEPS];
  logic                  dv_v_nxt   [0:DIV2_STEPS];
  logic                  dv_z_nxt   [0:DIV2_STEPS];
  logic                  dv_big_nxt [0:DIV2_STEPS];
  logic [CQ_BITS-1:0]    dv_cq_nxt  [0:DIV2_STEPS];
  logic [DEN_BITS-1:0]   dv_den_nxt [0:DIV2_STEPS];
  logic [DEN_BITS-1:0]   dv_rem_nxt [0:DIV2_STEPS];
  logic [VAL_BITS-1:0]   dv_quo_nxt [0:DIV2_STEPS];

  logic                  out_v_r, out_v_nxt;
  logic [VAL_BITS-1:0]   out_val_r, out_val_nxt;

  assign en        = !(out_v_r && out_stall);
  assign in_stall  = !en;
  assign out_valid = out_v_r;
  assign out_coefficient_value = out_val_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_type_r <= FILTER_RAMP;
      line_width_r  <= W_BITS'(4096);
      cutoff_r      <= CUT_BITS'(32768);
      order_r       <= ORD_BITS'(64);
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_FILTER_TYPE:  filter_type_r <= cfg_data[0];
        CFG_LINE_WIDTH:   line_width_r  <= cfg_data[W_BITS-1:0];
        CFG_CUTOFF_FRAC:  cutoff_r      <= cfg_data[CUT_BITS-1:0];
        CFG_ORDER_SCALED: order_r       <= cfg_data[ORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [W_BITS:0]       t1;
    logic                  ge1;
    logic [4:0]            mb;
    logic [2*MANT_BITS-1:0] sq;
    logic [CQ_BITS-1:0]    s;
    logic signed [7:0]     hi;
    logic [2*MANT_BITS-1:0] pr;
    logic [5:0]            nsh;
    logic [DEN_BITS:0]     t2;
    logic                  ge2;
    logic                  nb;

    // item setup
    w_lim = line_width_r & ~W_BITS'(3);
    if (w_lim > W_LIMIT) w_lim = W_LIMIT;
    w4    = w_lim[W_BITS-1:2];
    half  = w_lim[W_BITS-1:1];
    p     = in_coefficient_index[IDX_BITS-1:1];
    if (p < w4)       q = p;
    else if (p == w4) q = '0;
    else              q = Q_BITS'(half - {1'b0, p});
    idx_ok = (w_lim >= W_BITS'(4)) && ({1'b0, in_coefficient_index} < w_lim);

    d1_v_nxt[0]   = in_valid;
    d1_z_nxt[0]   = !idx_ok || (q == '0) || (filter_type_r != FILTER_RAMP && cutoff_r == '0);
    d1_rem_nxt[0] = {q, 2'b00};
    d1_quo_nxt[0] = '0;
    for (int k = 1; k <= DIV1_STEPS; k++) begin
      t1  = {d1_rem_r[k-1], 1'b0};
      ge1 = t1 >= {1'b0, w_lim};
      d1_v_nxt[k]   = d1_v_r[k-1];
      d1_z_nxt[k]   = d1_z_r[k-1];
      d1_rem_nxt[k] = ge1 ? W_BITS'(t1 - {1'b0, w_lim}) : t1[W_BITS-1:0];
      d1_quo_nxt[k] = {d1_quo_r[k-1][CQ_BITS-2:0], ge1};
    end

    // log2 entry: top bit and mantissa
    mb = msb_index(CQ_BITS'(cutoff_r));
    lg_v_nxt[0]  = d1_v_r[DIV1_STEPS];
    lg_z_nxt[0]  = d1_z_r[DIV1_STEPS];
    lg_cq_nxt[0] = d1_quo_r[DIV1_STEPS];
    lg_ma_nxt[0] = msb_index(d1_quo_r[DIV1_STEPS]);
    lg_mb_nxt[0] = mb;
    lg_xa_nxt[0] = normalize(d1_quo_r[DIV1_STEPS], msb_index(d1_quo_r[DIV1_STEPS]));
    lg_xb_nxt[0] = normalize(CQ_BITS'(cutoff_r), mb);
    lg_fa_nxt[0] = '0;
    lg_fb_nxt[0] = '0;
    for (int k = 1; k <= LOG_STEPS; k++) begin
      lg_v_nxt[k]  = lg_v_r[k-1];
      lg_z_nxt[k]  = lg_z_r[k-1];
      lg_cq_nxt[k] = lg_cq_r[k-1];
      lg_ma_nxt[k] = lg_ma_r[k-1];
      lg_mb_nxt[k] = lg_mb_r[k-1];
      sq = lg_xa_r[k-1] * lg_xa_r[k-1];
      s  = sq[61:30];
      lg_xa_nxt[k] = s[31] ? s[31:1] : s[30:0];
      lg_fa_nxt[k] = {lg_fa_r[k-1][FRAC_BITS-2:0], s[31]};
      sq = lg_xb_r[k-1] * lg_xb_r[k-1];
      s  = sq[61:30];
      lg_xb_nxt[k] = s[31] ? s[31:1] : s[30:0];
      lg_fb_nxt[k] = {lg_fb_r[k-1][FRAC_BITS-2:0], s[31]};
    end

    // lx = log2(c) - log2(cutoff), Q.16
    hi = 8'(lg_ma_r[LOG_STEPS]) - 8'(lg_mb_r[LOG_STEPS]) - 8'sd16;
    la_v_nxt  = lg_v_r[LOG_STEPS];
    la_z_nxt  = lg_z_r[LOG_STEPS];
    la_cq_nxt = lg_cq_r[LOG_STEPS];
    la_lx_nxt = {hi, 16'b0} + $signed({8'b0, lg_fa_r[LOG_STEPS]})
                - $signed({8'b0, lg_fb_r[LOG_STEPS]});

    lb_prod   = la_lx_r * $signed({1'b0, order_r});
    lb_v_nxt  = la_v_r;
    lb_z_nxt  = la_z_r;
    lb_cq_nxt = la_cq_r;
    lb_y_nxt  = 32'(lb_prod >>> 3);

    ex_v_nxt[0]   = lb_v_r;
    ex_z_nxt[0]   = lb_z_r;
    ex_cq_nxt[0]  = lb_cq_r;
    ex_yi_nxt[0]  = lb_y_r[31:16];
    ex_yf_nxt[0]  = lb_y_r[15:0];
    ex_acc_nxt[0] = MANT_BITS'(1) << 30;
    for (int k = 1; k <= EXP_STEPS; k++) begin
      ex_v_nxt[k]  = ex_v_r[k-1];
      ex_z_nxt[k]  = ex_z_r[k-1];
      ex_cq_nxt[k] = ex_cq_r[k-1];
      ex_yi_nxt[k] = ex_yi_r[k-1];
      ex_yf_nxt[k] = ex_yf_r[k-1];
      pr = ex_acc_r[k-1] * EXP_ROOT[k];
      ex_acc_nxt[k] = ex_yf_r[k-1][FRAC_BITS-k] ? pr[60:30] : ex_acc_r[k-1];
    end

    // denominator 1 + 2^y in Q34.30
    dn_v_nxt   = ex_v_r[EXP_STEPS];
    dn_z_nxt   = ex_z_r[EXP_STEPS];
    dn_cq_nxt  = ex_cq_r[EXP_STEPS];
    dn_big_nxt = ex_yi_r[EXP_STEPS] > 16'sd32;
    nsh        = 6'(-ex_yi_r[EXP_STEPS]);
    if (ex_yi_r[EXP_STEPS] >= 16'sd0)
      dn_den_nxt = (DEN_BITS'(1) << 30)
                   + (DEN_BITS'(ex_acc_r[EXP_STEPS]) << ex_yi_r[EXP_STEPS][5:0]);
    else if (ex_yi_r[EXP_STEPS] < -16'sd30)
      dn_den_nxt = DEN_BITS'(1) << 30;
    else
      dn_den_nxt = (DEN_BITS'(1) << 30) + DEN_BITS'(ex_acc_r[EXP_STEPS] >> nsh);

    dv_v_nxt[0]   = dn_v_r;
    dv_z_nxt[0]   = dn_z_r;
    dv_big_nxt[0] = dn_big_r;
    dv_cq_nxt[0]  = dn_cq_r;
    dv_den_nxt[0] = dn_den_r;
    dv_rem_nxt[0] = DEN_BITS'(dn_cq_r[CQ_BITS-1:2]);
    dv_quo_nxt[0] = '0;
    for (int k = 1; k <= DIV2_STEPS; k++) begin
      // numerator bits below c are zero
      nb  = (k == 1) ? dv_cq_r[k-1][1] : ((k == 2) ? dv_cq_r[k-1][0] : 1'b0);
      t2  = {dv_rem_r[k-1], nb};
      ge2 = t2 >= {1'b0, dv_den_r[k-1]};
      dv_v_nxt[k]   = dv_v_r[k-1];
      dv_z_nxt[k]   = dv_z_r[k-1];
      dv_big_nxt[k] = dv_big_r[k-1];
      dv_cq_nxt[k]  = dv_cq_r[k-1];
      dv_den_nxt[k] = dv_den_r[k-1];
      dv_rem_nxt[k] = ge2 ? DEN_BITS'(t2 - {1'b0, dv_den_r[k-1]}) : t2[DEN_BITS-1:0];
      dv_quo_nxt[k] = {dv_quo_r[k-1][VAL_BITS-2:0], ge2};
    end

    out_v_nxt = dv_v_r[DIV2_STEPS];
    if (dv_z_r[DIV2_STEPS])
      out_val_nxt = '0;
    else if (filter_type_r == FILTER_RAMP)
      out_val_nxt = VAL_BITS'(dv_cq_r[DIV2_STEPS] >> 12);
    else if (dv_big_r[DIV2_STEPS])
      out_val_nxt = '0;
    else
      out_val_nxt = dv_quo_r[DIV2_STEPS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_v_r <= '{default: 1'b0};
      lg_v_r <= '{default: 1'b0};
      la_v_r <= 1'b0;
      lb_v_r <= 1'b0;
      ex_v_r <= '{default: 1'b0};
      dn_v_r <= 1'b0;
      dv_v_r <= '{default: 1'b0};
      out_v_r <= 1'b0;
    end else if (en) begin
      d1_v_r <= d1_v_nxt;
      lg_v_r <= lg_v_nxt;
      la_v_r <= la_v_nxt;
      lb_v_r <= lb_v_nxt;
      ex_v_r <= ex_v_nxt;
      dn_v_r <= dn_v_nxt;
      dv_v_r <= dv_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_z_r   <= d1_z_nxt;
      d1_rem_r <= d1_rem_nxt;
      d1_quo_r <= d1_quo_nxt;
      lg_z_r   <= lg_z_nxt;
      lg_cq_r  <= lg_cq_nxt;
      lg_ma_r  <= lg_ma_nxt;
      lg_mb_r  <= lg_mb_nxt;
      lg_xa_r  <= lg_xa_nxt;
      lg_xb_r  <= lg_xb_nxt;
      lg_fa_r  <= lg_fa_nxt;
      lg_fb_r  <= lg_fb_nxt;
      la_z_r   <= la_z_nxt;
      la_cq_r  <= la_cq_nxt;
      la_lx_r  <= la_lx_nxt;
      lb_z_r   <= lb_z_nxt;
      lb_cq_r  <= lb_cq_nxt;
      lb_y_r   <= lb_y_nxt;
      ex_z_r   <= ex_z_nxt;
      ex_cq_r  <= ex_cq_nxt;
      ex_yi_r  <= ex_yi_nxt;
      ex_yf_r  <= ex_yf_nxt;
      ex_acc_r <= ex_acc_nxt;
      dn_z_r   <= dn_z_nxt;
      dn_cq_r  <= dn_cq_nxt;
      dn_big_r <= dn_big_nxt;
      dn_den_r <= dn_den_nxt;
      dv_z_r   <= dv_z_nxt;
      dv_big_r <= dv_big_nxt;
      dv_cq_r  <= dv_cq_nxt;
      dv_den_r <= dv_den_nxt;
      dv_rem_r <= dv_rem_nxt;
      dv_quo_r <= dv_quo_nxt;
      out_val_r <= out_val_nxt;
    end
  end

endmodule
`default_nettype wire
